// ===== sv/lcs_pkg.sv =====
// Shared types and constants for the loop candidate search block.
// Used by lcs_dist, loop_candidate_search and lcs_checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lcs_pkg;

  localparam int MAX_FRAMES_DEF = 4096;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int MATCH_W    = 12;
  localparam int DIST_W     = 34;
  localparam int SKIP_W     = 16;
  localparam int DN_W       = 13;
  localparam int EFN_W      = 12;
  localparam int AREA_W     = 32;
  localparam int LIM_SHIFT  = 9;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_MIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_MIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXTEND_NUM = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_THR   = 2'd3;

  localparam logic [SKIP_W-1:0] STEP_MIN_RST   = 16'd5;
  localparam logic [DN_W-1:0]   GAP_MIN_RST    = 13'd100;
  localparam logic [EFN_W-1:0]  EXTEND_NUM_RST = 12'd5;
  localparam logic [AREA_W-1:0] NEAR_THR_RST   = 32'd1280;
  localparam logic [SKIP_W-1:0] SKIP_MAX       = 16'hFFFF;

  localparam logic [DIST_W-1:0] INIT_MIN_DIST = 34'd256000000;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } pos_t;

  typedef struct packed {
    logic                searched;
    logic                found;
    logic [MATCH_W-1:0]  match_index;
    logic [DIST_W-1:0]   best_dist;
    logic                store_full;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/lcs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Holds the key-frame position store; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module lcs_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== sv/lcs_dist.sv =====
// Two-stage L1 distance unit: absolute differences, then their sum.
// Shared by every history entry of a search; uses lcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcs_dist #(
  parameter int ADDR_W = 12
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_v,
  input  wire logic [ADDR_W-1:0]         in_idx,
  input  wire lcs_pkg::pos_t             query,
  input  wire lcs_pkg::pos_t             entry,
  output logic                           out_v,
  output logic [ADDR_W-1:0]              out_idx,
  output logic [lcs_pkg::DIST_W-1:0]     out_dist,
  output logic                           busy
);

  function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] d;
    d = {a[31], a} - {b[31], b};
    return d[32] ? 32'(-d) : d[31:0];
  endfunction

  logic                          a_v_r, a_v_nxt;
  logic [ADDR_W-1:0]             a_idx_r;
  logic [31:0]                   dx_r, dy_r, dz_r;
  logic                          b_v_r, b_v_nxt;
  logic [ADDR_W-1:0]             b_idx_r;
  logic [lcs_pkg::DIST_W-1:0]    sum_r, sum_nxt;

  assign a_v_nxt = in_v;
  assign b_v_nxt = a_v_r;
  assign sum_nxt = lcs_pkg::DIST_W'(dx_r) + lcs_pkg::DIST_W'(dy_r) + lcs_pkg::DIST_W'(dz_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      a_v_r <= a_v_nxt;
      b_v_r <= b_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_idx_r <= in_idx;
    dx_r    <= abs_diff(query.pos_x, entry.pos_x);
    dy_r    <= abs_diff(query.pos_y, entry.pos_y);
    dz_r    <= abs_diff(query.pos_z, entry.pos_z);
    b_idx_r <= a_idx_r;
    sum_r   <= sum_nxt;
  end

  assign out_v    = b_v_r;
  assign out_idx  = b_idx_r;
  assign out_dist = sum_r;
  assign busy     = a_v_r | b_v_r;

endmodule

`default_nettype wire

// ===== sv/loop_candidate_search.sv =====
// Loop candidate search: key-frame position store with nearest-entry search.
// Instantiates lcs_ram and lcs_dist; uses lcs_pkg.
//
// Usage:
//   in_valid/in_stall/in_data carry one key-frame position (x, y, z).
//   out_valid/out_stall/out_data carry one result per accepted frame.
//   cfg_we/cfg_index/cfg_wdata write the search step, the minimum frame gap,
//   the smallest match index and the near threshold; write only while idle.
// Each accepted frame is written to the store at the current frame count,
// unless the store is full. When the skip counter and frame count allow, the
// history is walked one entry per cycle through the RAM read port and the
// distance unit; the earliest entry with the smallest L1 distance wins.
// in_stall is high from accept until the result moves to the output register.
// A result waits in the output register while out_stall is high; the next
// frame is accepted meanwhile, and its own result waits until that register
// empties. Reset clears the frame count, skip state and registers to their
// reset values; the store content is left as is and is never read unwritten.
`timescale 1ns / 1ps
`default_nettype none

module loop_candidate_search #(
  parameter int MAX_FRAMES = lcs_pkg::MAX_FRAMES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire lcs_pkg::pos_t                     in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output lcs_pkg::res_t                          out_data,
  input  wire logic                              cfg_we,
  input  wire logic [lcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [lcs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int ADDR_W = $clog2(MAX_FRAMES);
  localparam int FC_W   = ADDR_W + 1;
  localparam int NW     = (FC_W > lcs_pkg::DN_W) ? FC_W : lcs_pkg::DN_W;
  localparam int CW     = (ADDR_W > lcs_pkg::EFN_W) ? ADDR_W : lcs_pkg::EFN_W;
  localparam int HW     = lcs_pkg::DIST_W - lcs_pkg::LIM_SHIFT;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t                           state_r, state_nxt;
  lcs_pkg::pos_t                    q_r;
  logic [FC_W-1:0]                  fc_r, fc_nxt;
  logic [lcs_pkg::SKIP_W-1:0]       skip_ctr_r, skip_ctr_nxt;
  logic [lcs_pkg::SKIP_W-1:0]       skip_lim_r, skip_lim_nxt;
  logic [lcs_pkg::SKIP_W-1:0]       step_min_r;
  logic [lcs_pkg::DN_W-1:0]         gap_min_r;
  logic [lcs_pkg::EFN_W-1:0]        efn_r;
  logic [lcs_pkg::AREA_W-1:0]       area_r;
  logic [FC_W-1:0]                  cnt_r;
  logic [FC_W-1:0]                  iss_r, iss_nxt;
  logic                             rd_v_r;
  logic [ADDR_W-1:0]                rd_idx_r;
  logic [lcs_pkg::DIST_W-1:0]       md_r, md_nxt;
  logic [ADDR_W-1:0]                best_r, best_nxt;
  logic                             have_r, have_nxt;
  logic                             searched_r;
  logic                             full_r;
  logic                             out_valid_r, out_valid_nxt;
  lcs_pkg::res_t                    out_data_r;

  logic                             in_acc;
  logic                             full_w;
  logic [FC_W-1:0]                  n_w;
  logic [lcs_pkg::SKIP_W-1:0]       sc_inc;
  logic                             do_search;
  logic [NW-1:0]                    cnt_wide;
  logic                             issue;
  logic                             fin_go;
  logic                             found_w;
  logic [HW-1:0]                    half_w;
  logic [lcs_pkg::SKIP_W-1:0]       lim_new;
  lcs_pkg::pos_t                    entry_w;
  logic [$bits(lcs_pkg::pos_t)-1:0] rd_data;
  logic                             d_v;
  logic [ADDR_W-1:0]                d_idx;
  logic [lcs_pkg::DIST_W-1:0]       d_dist;
  logic                             d_busy;
  lcs_pkg::res_t                    res_w;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign full_w   = (fc_r == FC_W'(MAX_FRAMES));
  assign n_w      = fc_r + FC_W'(1);
  assign sc_inc   = (skip_ctr_r == lcs_pkg::SKIP_MAX) ? skip_ctr_r
                                                      : skip_ctr_r + lcs_pkg::SKIP_W'(1);
  assign do_search = !full_w && (sc_inc >= skip_lim_r) && (NW'(n_w) > NW'(gap_min_r));
  assign cnt_wide  = (gap_min_r < lcs_pkg::DN_W'(2)) ? (NW'(n_w) - NW'(1))
                                                     : (NW'(n_w) + NW'(1) - NW'(gap_min_r));
  assign issue     = (state_r == ST_SEARCH) && (iss_r != cnt_r);
  assign fin_go    = (state_r == ST_FINISH) && (!out_valid_r || !out_stall);
  assign found_w   = searched_r && have_r && (CW'(best_r) >= CW'(efn_r));
  assign half_w    = md_r[lcs_pkg::DIST_W-1:lcs_pkg::LIM_SHIFT];

  lcs_ram #(
    .WIDTH ($bits(lcs_pkg::pos_t)),
    .DEPTH (MAX_FRAMES)
  ) u_store (
    .clk     (clk),
    .wr_en   (in_acc && !full_w),
    .wr_addr (fc_r[ADDR_W-1:0]),
    .wr_data (in_data),
    .rd_addr (iss_r[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  assign entry_w = rd_data;

  lcs_dist #(
    .ADDR_W (ADDR_W)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (rd_v_r),
    .in_idx   (rd_idx_r),
    .query    (q_r),
    .entry    (entry_w),
    .out_v    (d_v),
    .out_idx  (d_idx),
    .out_dist (d_dist),
    .busy     (d_busy)
  );

  always_comb begin
    if (md_r > lcs_pkg::DIST_W'(area_r)) begin
      if (half_w < HW'(step_min_r)) begin
        lim_new = step_min_r;
      end else if (half_w > HW'(lcs_pkg::SKIP_MAX)) begin
        lim_new = lcs_pkg::SKIP_MAX;
      end else begin
        lim_new = half_w[lcs_pkg::SKIP_W-1:0];
      end
    end else begin
      lim_new = step_min_r;
    end
  end

  always_comb begin
    res_w.searched     = searched_r;
    res_w.found        = found_w;
    res_w.match_index  = found_w ? lcs_pkg::MATCH_W'(best_r) : '0;
    res_w.best_dist    = searched_r ? md_r : '0;
    res_w.store_full   = full_r;
  end

  always_comb begin
    state_nxt     = state_r;
    fc_nxt        = fc_r;
    skip_ctr_nxt  = skip_ctr_r;
    skip_lim_nxt  = skip_lim_r;
    iss_nxt       = iss_r;
    md_nxt        = md_r;
    best_nxt      = best_r;
    have_nxt      = have_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          md_nxt   = lcs_pkg::INIT_MIN_DIST;
          have_nxt = 1'b0;
          best_nxt = '0;
          iss_nxt  = '0;
          if (!full_w) begin
            fc_nxt       = n_w;
            skip_ctr_nxt = sc_inc;
          end
          state_nxt = do_search ? ST_SEARCH : ST_FINISH;
        end
      end
      ST_SEARCH: begin
        if (issue) begin
          iss_nxt = iss_r + FC_W'(1);
        end
        if (d_v && (d_dist < md_r)) begin
          md_nxt   = d_dist;
          best_nxt = d_idx;
          have_nxt = 1'b1;
        end
        if (!issue && !rd_v_r && !d_busy) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (fin_go) begin
          out_valid_nxt = 1'b1;
          if (found_w) begin
            skip_ctr_nxt = '0;
            skip_lim_nxt = lim_new;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (cfg_we && (cfg_index == lcs_pkg::REG_STEP_MIN)) begin
      skip_lim_nxt = cfg_wdata[lcs_pkg::SKIP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fc_r        <= '0;
      skip_ctr_r  <= '0;
      skip_lim_r  <= lcs_pkg::STEP_MIN_RST;
      step_min_r  <= lcs_pkg::STEP_MIN_RST;
      gap_min_r   <= lcs_pkg::GAP_MIN_RST;
      efn_r       <= lcs_pkg::EXTEND_NUM_RST;
      area_r      <= lcs_pkg::NEAR_THR_RST;
      iss_r       <= '0;
      rd_v_r      <= 1'b0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fc_r        <= fc_nxt;
      skip_ctr_r  <= skip_ctr_nxt;
      skip_lim_r  <= skip_lim_nxt;
      iss_r       <= iss_nxt;
      rd_v_r      <= issue;
      have_r      <= have_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          lcs_pkg::REG_STEP_MIN:   step_min_r <= cfg_wdata[lcs_pkg::SKIP_W-1:0];
          lcs_pkg::REG_GAP_MIN:    gap_min_r  <= cfg_wdata[lcs_pkg::DN_W-1:0];
          lcs_pkg::REG_EXTEND_NUM: efn_r      <= cfg_wdata[lcs_pkg::EFN_W-1:0];
          lcs_pkg::REG_NEAR_THR:   area_r     <= cfg_wdata[lcs_pkg::AREA_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      q_r        <= in_data;
      cnt_r      <= FC_W'(cnt_wide);
      searched_r <= do_search;
      full_r     <= full_w;
    end
    rd_idx_r <= iss_r[ADDR_W-1:0];
    md_r     <= md_nxt;
    best_r   <= best_nxt;
    if (fin_go) begin
      out_data_r <= res_w;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== sv/lcs_checker.sv =====
// Port-level checks for loop_candidate_search, bound to the top level.
// Uses lcs_pkg types; sees only the top-level ports.
`timescale 1ns / 1ps
`default_nettype none

module lcs_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_stall,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire lcs_pkg::res_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again while a frame is in work");

  a_found_needs_search: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> out_data.searched && !out_data.store_full)
    else $error("match reported without a search");

  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.store_full |->
      !out_data.searched && (out_data.best_dist == '0) && (out_data.match_index == '0))
    else $error("dropped frame carries search fields");

  a_no_search_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.searched |-> (out_data.best_dist == '0) && !out_data.found)
    else $error("distance reported without a search");

endmodule

bind loop_candidate_search lcs_checker u_lcs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
